[src/r9tw_pkg.sv]
// ----------------------------------------------------------------------------
// r9tw_pkg
// Types, constants and arithmetic helpers for the radix-9 twiddled butterfly.
// ----------------------------------------------------------------------------
package r9tw_pkg;

  localparam int SampleW  = 16;
  localparam int TwidW    = 16;
  localparam int FracBits = 14;
  localparam int OutW     = 20;
  localparam int ValW     = 32;
  localparam int ProdW    = 48;
  localparam int NPts     = 9;
  localparam int PtW      = 4;

  typedef logic signed [ValW-1:0]  val_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [TwidW-1:0] kconst_t;
  typedef logic signed [OutW-1:0]  oval_t;

  typedef struct packed {
    val_t re;
    val_t im;
  } cpx_t;

  typedef cpx_t [NPts-1:0] batch_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CALC,
    BK_EMIT
  } bk_state_t;

  // cos20, sin20, cos10, sin10, sin40, cos40, 1/2, sqrt3/2 in Q1.14
  localparam kconst_t K1 = 16'sd15396;
  localparam kconst_t K2 = 16'sd5604;
  localparam kconst_t K3 = 16'sd16135;
  localparam kconst_t K4 = 16'sd2845;
  localparam kconst_t K5 = 16'sd10531;
  localparam kconst_t K6 = 16'sd12551;
  localparam kconst_t K7 = 16'sd8192;
  localparam kconst_t K8 = 16'sd14189;

  localparam prod_t RndHalf = prod_t'(1) <<< (FracBits - 1);

  function automatic val_t rnd(input prod_t p);
    prod_t t;
    t = (p + RndHalf) >>> FracBits;
    return t[ValW-1:0];
  endfunction

  function automatic val_t mk(input kconst_t k, input val_t v);
    prod_t p;
    p = prod_t'(k) * prod_t'(v);
    return rnd(p);
  endfunction

  function automatic val_t rot(input kconst_t ka, input val_t a,
                               input kconst_t kb, input val_t b);
    prod_t p;
    p = prod_t'(ka) * prod_t'(a) + prod_t'(kb) * prod_t'(b);
    return rnd(p);
  endfunction

  function automatic oval_t sat(input val_t v);
    val_t hi;
    val_t lo;
    hi = val_t'((64'sd1 <<< (OutW - 1)) - 1);
    lo = -hi - 1;
    if (v > hi) return hi[OutW-1:0];
    if (v < lo) return lo[OutW-1:0];
    return v[OutW-1:0];
  endfunction

endpackage

[src/r9tw_front.sv]
// ----------------------------------------------------------------------------
// r9tw_front
// Accepts points, applies twiddles, collects nine points into a batch.
// ----------------------------------------------------------------------------
module r9tw_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [15:0]          in_sample_re,
  input  logic signed [15:0]          in_sample_im,
  input  logic signed [15:0]          in_twiddle_re,
  input  logic signed [15:0]          in_twiddle_im,
  input  logic                        q_full,
  output logic                        push,
  output r9tw_pkg::batch_t            push_data
);
  import r9tw_pkg::*;

  logic [PtW-1:0] cnt_r, cnt_nxt;
  cpx_t [NPts-2:0] pts_r;
  cpx_t            pt;
  logic            acc;
  logic            lastpt;

  assign lastpt = (cnt_r == PtW'(NPts - 1));
  assign busy   = lastpt && q_full;
  assign acc    = start && !busy;
  assign push   = acc && lastpt;

  always_comb begin
    if (cnt_r == '0) begin
      pt.re = val_t'(in_sample_re);
      pt.im = val_t'(in_sample_im);
    end else begin
      pt.re = rnd(prod_t'(in_twiddle_re) * prod_t'(in_sample_re)
                  - prod_t'(in_twiddle_im) * prod_t'(in_sample_im));
      pt.im = rot(in_twiddle_im, val_t'(in_sample_re),
                  in_twiddle_re, val_t'(in_sample_im));
    end
    push_data[NPts-2:0] = pts_r;
    push_data[NPts-1]   = pt;
    cnt_nxt = cnt_r;
    if (acc) cnt_nxt = lastpt ? '0 : cnt_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else        cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (acc && !lastpt) pts_r[cnt_r[2:0]] <= pt;
  end

endmodule

[src/r9tw_queue.sv]
// ----------------------------------------------------------------------------
// r9tw_queue
// Two-entry batch queue between front and back.
// ----------------------------------------------------------------------------
module r9tw_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  r9tw_pkg::batch_t push_data,
  input  logic             pop,
  output r9tw_pkg::batch_t pop_data,
  output logic             full,
  output logic             empty
);
  import r9tw_pkg::*;

  batch_t     mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] n_r;

  assign full     = (n_r == 2'd2);
  assign empty    = (n_r == 2'd0);
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      n_r  <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      n_r <= n_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

endmodule

[src/r9tw_back.sv]
// ----------------------------------------------------------------------------
// r9tw_back
// Seven-stage radix-9 butterfly datapath and result sequencer.
// ----------------------------------------------------------------------------
module r9tw_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  r9tw_pkg::batch_t       q_data,
  output logic                   pop,
  output logic                   out_valid,
  output logic signed [19:0]     out_re,
  output logic signed [19:0]     out_im,
  output logic [3:0]             out_point,
  output logic                   out_last
);
  import r9tw_pkg::*;

  localparam int CalcCycles = 6;

  bk_state_t st_r, st_nxt;
  logic [2:0]     cc_r, cc_nxt;
  logic [PtW-1:0] ix_r, ix_nxt;
  logic           ov_nxt;

  cpx_t x_r [9];
  cpx_t s1_u [3], s1_s [3], s1_g0 [3];
  val_t s1_dre [3], s1_dim [3];
  cpx_t s2_gh [3], s2_gs, s2_g00;
  val_t s2_dr [3], s2_di [3], s2_gdr, s2_gdi;
  cpx_t s3_b1 [2], s3_b2 [2], s3_a1, s3_a2, s3_y0, s3_h0;
  val_t s3_tr, s3_ti;
  cpx_t s4_p1, s4_q1, s4_p2, s4_q2, s4_a1, s4_a2, s4_y0, s4_y3, s4_y6;
  cpx_t s5_t1a, s5_d3a, s5_t1b, s5_d3b, s5_a1, s5_a2, s5_y0, s5_y3, s5_y6;
  cpx_t s6_y1, s6_y2, s6_h1, s6_h2, s6_t3a, s6_t3b, s6_y0, s6_y3, s6_y6;
  cpx_t y [9];
  oval_t yr_re [9], yr_im [9];

  assign pop = (st_r == BK_IDLE) && !q_empty;

  always_comb begin
    st_nxt = st_r;
    cc_nxt = cc_r;
    ix_nxt = ix_r;
    ov_nxt = 1'b0;
    unique case (st_r)
      BK_IDLE: begin
        if (!q_empty) begin
          st_nxt = BK_CALC;
          cc_nxt = '0;
        end
      end
      BK_CALC: begin
        cc_nxt = cc_r + 1'b1;
        if (cc_r == 3'(CalcCycles)) begin
          st_nxt = BK_EMIT;
          ix_nxt = '0;
        end
      end
      BK_EMIT: begin
        ov_nxt = 1'b1;
        ix_nxt = ix_r + 1'b1;
        if (ix_r == PtW'(NPts - 1)) st_nxt = BK_IDLE;
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= BK_IDLE;
      cc_r      <= '0;
      ix_r      <= '0;
      out_valid <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      cc_r      <= cc_nxt;
      ix_r      <= ix_nxt;
      out_valid <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == BK_EMIT) begin
      out_re    <= yr_re[ix_r];
      out_im    <= yr_im[ix_r];
      out_point <= ix_r;
      out_last  <= (ix_r == PtW'(NPts - 1));
    end
  end

  always_comb begin
    y[0] = s6_y0;
    y[3] = s6_y3;
    y[6] = s6_y6;
    y[1] = s6_y1;
    y[2] = s6_y2;
    y[4].re = s6_h1.re + s6_t3a.im;  y[4].im = s6_h1.im + s6_t3a.re;
    y[7].re = s6_h1.re - s6_t3a.im;  y[7].im = s6_h1.im - s6_t3a.re;
    y[5].re = s6_h2.re + s6_t3b.im;  y[5].im = s6_h2.im + s6_t3b.re;
    y[8].re = s6_h2.re - s6_t3b.im;  y[8].im = s6_h2.im - s6_t3b.re;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < 9; i++) x_r[i] <= q_data[i];
    end
    // stage 1: first radix-3 sums
    for (int g = 0; g < 3; g++) begin
      s1_u[g]     <= x_r[g];
      s1_s[g].re  <= x_r[g+3].re + x_r[g+6].re;
      s1_s[g].im  <= x_r[g+3].im + x_r[g+6].im;
      s1_dre[g]   <= x_r[g+6].re - x_r[g+3].re;
      s1_dim[g]   <= x_r[g+3].im - x_r[g+6].im;
      s1_g0[g].re <= x_r[g].re + x_r[g+3].re + x_r[g+6].re;
      s1_g0[g].im <= x_r[g].im + x_r[g+3].im + x_r[g+6].im;
    end
    // stage 2
    for (int g = 0; g < 3; g++) begin
      s2_dr[g]    <= mk(K8, s1_dre[g]);
      s2_di[g]    <= mk(K8, s1_dim[g]);
      s2_gh[g].re <= s1_u[g].re - mk(K7, s1_s[g].re);
      s2_gh[g].im <= s1_u[g].im - mk(K7, s1_s[g].im);
    end
    s2_gs.re <= s1_g0[1].re + s1_g0[2].re;
    s2_gs.im <= s1_g0[1].im + s1_g0[2].im;
    s2_gdr   <= s1_g0[2].re - s1_g0[1].re;
    s2_gdi   <= s1_g0[1].im - s1_g0[2].im;
    s2_g00   <= s1_g0[0];
    // stage 3
    s3_tr    <= mk(K8, s2_gdr);
    s3_ti    <= mk(K8, s2_gdi);
    s3_y0.re <= s2_g00.re + s2_gs.re;
    s3_y0.im <= s2_g00.im + s2_gs.im;
    s3_h0.re <= s2_g00.re - mk(K7, s2_gs.re);
    s3_h0.im <= s2_g00.im - mk(K7, s2_gs.im);
    for (int g = 0; g < 2; g++) begin
      s3_b1[g].re <= s2_gh[g+1].re + s2_di[g+1];
      s3_b2[g].re <= s2_gh[g+1].re - s2_di[g+1];
      s3_b1[g].im <= s2_gh[g+1].im + s2_dr[g+1];
      s3_b2[g].im <= s2_gh[g+1].im - s2_dr[g+1];
    end
    s3_a1.re <= s2_gh[0].re + s2_di[0];
    s3_a1.im <= s2_gh[0].im + s2_dr[0];
    s3_a2.re <= s2_gh[0].re - s2_di[0];
    s3_a2.im <= s2_gh[0].im - s2_dr[0];
    // stage 4: inner rotations
    s4_p1.re <= rot(K6, s3_b1[0].re, K5, s3_b1[0].im);
    s4_p1.im <= rot(K6, s3_b1[0].im, -K5, s3_b1[0].re);
    s4_q1.re <= rot(K4, s3_b1[1].re, K3, s3_b1[1].im);
    s4_q1.im <= rot(K4, s3_b1[1].im, -K3, s3_b1[1].re);
    s4_p2.re <= rot(K4, s3_b2[0].re, K3, s3_b2[0].im);
    s4_p2.im <= rot(K4, s3_b2[0].im, -K3, s3_b2[0].re);
    s4_q2.re <= rot(K2, s3_b2[1].im, -K1, s3_b2[1].re);
    s4_q2.im <= rot(K1, s3_b2[1].im, K2, s3_b2[1].re);
    s4_a1 <= s3_a1;
    s4_a2 <= s3_a2;
    s4_y0 <= s3_y0;
    s4_y3.re <= s3_h0.re + s3_ti;  s4_y3.im <= s3_h0.im + s3_tr;
    s4_y6.re <= s3_h0.re - s3_ti;  s4_y6.im <= s3_h0.im - s3_tr;
    // stage 5
    s5_t1a.re <= s4_p1.re + s4_q1.re;
    s5_t1a.im <= s4_p1.im + s4_q1.im;
    s5_d3a.re <= s4_q1.re - s4_p1.re;
    s5_d3a.im <= s4_p1.im - s4_q1.im;
    s5_t1b.re <= s4_p2.re + s4_q2.re;
    s5_t1b.im <= s4_p2.im - s4_q2.im;
    s5_d3b.re <= s4_q2.re - s4_p2.re;
    s5_d3b.im <= s4_p2.im + s4_q2.im;
    s5_a1 <= s4_a1;
    s5_a2 <= s4_a2;
    s5_y0 <= s4_y0;
    s5_y3 <= s4_y3;
    s5_y6 <= s4_y6;
    // stage 6
    s6_t3a.re <= mk(K8, s5_d3a.re);
    s6_t3a.im <= mk(K8, s5_d3a.im);
    s6_t3b.re <= mk(K8, s5_d3b.re);
    s6_t3b.im <= mk(K8, s5_d3b.im);
    s6_y1.re  <= s5_a1.re + s5_t1a.re;
    s6_y1.im  <= s5_a1.im + s5_t1a.im;
    s6_y2.re  <= s5_a2.re + s5_t1b.re;
    s6_y2.im  <= s5_a2.im + s5_t1b.im;
    s6_h1.re  <= s5_a1.re - mk(K7, s5_t1a.re);
    s6_h1.im  <= s5_a1.im - mk(K7, s5_t1a.im);
    s6_h2.re  <= s5_a2.re - mk(K7, s5_t1b.re);
    s6_h2.im  <= s5_a2.im - mk(K7, s5_t1b.im);
    s6_y0 <= s5_y0;
    s6_y3 <= s5_y3;
    s6_y6 <= s5_y6;
    // stage 7: saturate into result buffer
    for (int i = 0; i < 9; i++) begin
      yr_re[i] <= sat(y[i].re);
      yr_im[i] <= sat(y[i].im);
    end
  end

endmodule

[src/radix9_twiddle_fft_butterfly.sv]
// ----------------------------------------------------------------------------
// radix9_twiddle_fft_butterfly
// Radix-9 DIT butterfly with input twiddles, fixed point.
// ----------------------------------------------------------------------------
// Points 0..8 enter one per cycle while busy is low; points 1..8 are twiddled
// on entry. Nine points form a batch that waits in a two-batch queue. The
// back end takes a batch, runs it through its seven-stage butterfly datapath,
// then emits nine results on consecutive cycles (out_valid, point index,
// out_last on point 8) and takes no new batch until its last result is out.
// Results cannot be held off. busy rises only on a ninth point while the
// queue holds two batches.
module radix9_twiddle_fft_butterfly (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic signed [15:0]  in_sample_re,
  input  logic signed [15:0]  in_sample_im,
  input  logic signed [15:0]  in_twiddle_re,
  input  logic signed [15:0]  in_twiddle_im,
  output logic                out_valid,
  output logic signed [19:0]  out_re,
  output logic signed [19:0]  out_im,
  output logic [3:0]          out_point,
  output logic                out_last
);
  import r9tw_pkg::*;

  logic   push, pop, q_full, q_empty;
  batch_t push_data, pop_data;

  r9tw_front u_front (
    .clk, .rst_n, .start, .busy,
    .in_sample_re, .in_sample_im, .in_twiddle_re, .in_twiddle_im,
    .q_full, .push, .push_data
  );

  r9tw_queue u_queue (
    .clk, .rst_n, .push, .push_data, .pop, .pop_data,
    .full(q_full), .empty(q_empty)
  );

  r9tw_back u_back (
    .clk, .rst_n, .q_empty, .q_data(pop_data), .pop,
    .out_valid, .out_re, .out_im, .out_point, .out_last
  );

endmodule

[src/r9tw_checker.sv]
// ----------------------------------------------------------------------------
// r9tw_checker
// Port-level checks on the result sequence of the butterfly.
// ----------------------------------------------------------------------------
module r9tw_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic [3:0] out_point,
  input logic       out_last
);

  a_last_pt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_point == 4'd8)
    else $error("last not on point 8");

  a_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid && out_point == $past(out_point) + 4'd1)
    else $error("result run broken");

  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> out_point == 4'd0)
    else $error("run does not start at point 0");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_point <= 4'd8)
    else $error("point index out of range");

endmodule

bind radix9_twiddle_fft_butterfly r9tw_checker u_r9tw_checker (
  .clk, .rst_n, .out_valid, .out_point, .out_last
);

[verif/tb_radix9_twiddle_fft_butterfly.sv]
// ----------------------------------------------------------------------------
// tb_radix9_twiddle_fft_butterfly
// Drives random and directed nine-point batches into the radix-9 butterfly,
// predicts each batch's nine results in fixed point and checks every output.
// ----------------------------------------------------------------------------
module tb_radix9_twiddle_fft_butterfly;
  timeunit 1ns;
  timeprecision 1ps;

  import r9tw_pkg::*;

  typedef struct {
    logic signed [15:0] sr;
    logic signed [15:0] si;
    logic signed [15:0] tr;
    logic signed [15:0] ti;
    bit                 hold;
  } request_t;

  typedef struct {
    logic signed [19:0] re;
    logic signed [19:0] im;
    logic [3:0]         pt;
    logic               last;
  } spectrum_pt_t;

  typedef struct {
    longint re;
    longint im;
  } wide_cpx_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [15:0] in_sample_re;
  logic signed [15:0] in_sample_im;
  logic signed [15:0] in_twiddle_re;
  logic signed [15:0] in_twiddle_im;
  logic out_valid;
  logic signed [19:0] out_re;
  logic signed [19:0] out_im;
  logic [3:0] out_point;
  logic out_last;

  request_t     pending_q[$];
  spectrum_pt_t spectrum_q[$];
  wide_cpx_t    twiddled_pts[9];
  int           pt_idx;
  int           errors;
  int           idle_cnt;
  int           stall_left;
  bit           gaps_on;
  bit           feeding_done;
  bit           hold_active;

  radix9_twiddle_fft_butterfly dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_sample_re(in_sample_re), .in_sample_im(in_sample_im),
    .in_twiddle_re(in_twiddle_re), .in_twiddle_im(in_twiddle_im),
    .out_valid(out_valid), .out_re(out_re), .out_im(out_im),
    .out_point(out_point), .out_last(out_last)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic longint round_q14(input longint v);
    return (v + 64'sd8192) >>> 14;
  endfunction

  function automatic longint kval(input int i);
    longint q31[8];
    q31 = '{2017974537, 734482665, 2114858546, 372906622,
            1380375881, 1645067915, 1073741824, 1859775393};
    return (q31[i] + (64'sd1 <<< 16)) >>> 17;
  endfunction

  function automatic logic signed [19:0] clamp20(input longint v);
    if (v > 524287) return 20'sd524287;
    if (v < -524288) return -20'sd524288;
    return v[19:0];
  endfunction

  function automatic longint rotate(input longint ka, input longint a,
                                    input longint kb, input longint b);
    return round_q14(ka * a + kb * b);
  endfunction

  task automatic predict_spectrum();
    longint k1, k2, k3, k4, k5, k6, k7, k8;
    wide_cpx_t g0[3], gh[3], y[9], a1, a2, b1[2], b2[2], p, q, s, h;
    longint dr[3], di[3], tr, ti, t1r, t1i, t3r, t3i;
    spectrum_pt_t e;
    k1 = kval(0); k2 = kval(1); k3 = kval(2); k4 = kval(3);
    k5 = kval(4); k6 = kval(5); k7 = kval(6); k8 = kval(7);
    for (int g = 0; g < 3; g++) begin
      s.re = twiddled_pts[g+3].re + twiddled_pts[g+6].re;
      s.im = twiddled_pts[g+3].im + twiddled_pts[g+6].im;
      dr[g] = round_q14(k8 * (twiddled_pts[g+6].re - twiddled_pts[g+3].re));
      di[g] = round_q14(k8 * (twiddled_pts[g+3].im - twiddled_pts[g+6].im));
      g0[g].re = twiddled_pts[g].re + s.re;
      g0[g].im = twiddled_pts[g].im + s.im;
      gh[g].re = twiddled_pts[g].re - round_q14(k7 * s.re);
      gh[g].im = twiddled_pts[g].im - round_q14(k7 * s.im);
    end
    s.re = g0[1].re + g0[2].re;
    s.im = g0[1].im + g0[2].im;
    tr = round_q14(k8 * (g0[2].re - g0[1].re));
    ti = round_q14(k8 * (g0[1].im - g0[2].im));
    y[0].re = g0[0].re + s.re;
    y[0].im = g0[0].im + s.im;
    h.re = g0[0].re - round_q14(k7 * s.re);
    h.im = g0[0].im - round_q14(k7 * s.im);
    y[3].re = h.re + ti; y[3].im = h.im + tr;
    y[6].re = h.re - ti; y[6].im = h.im - tr;
    for (int g = 0; g < 2; g++) begin
      b1[g].re = gh[g+1].re + di[g+1];
      b2[g].re = gh[g+1].re - di[g+1];
      b1[g].im = gh[g+1].im + dr[g+1];
      b2[g].im = gh[g+1].im - dr[g+1];
    end
    a1.re = gh[0].re + di[0]; a1.im = gh[0].im + dr[0];
    a2.re = gh[0].re - di[0]; a2.im = gh[0].im - dr[0];

    p.re = rotate(k6, b1[0].re, k5, b1[0].im);
    p.im = rotate(k6, b1[0].im, -k5, b1[0].re);
    q.re = rotate(k4, b1[1].re, k3, b1[1].im);
    q.im = rotate(k4, b1[1].im, -k3, b1[1].re);
    t3r = round_q14(k8 * (q.re - p.re));
    t1r = p.re + q.re;
    t3i = round_q14(k8 * (p.im - q.im));
    t1i = p.im + q.im;
    y[1].re = a1.re + t1r;
    y[1].im = a1.im + t1i;
    h.re = a1.re - round_q14(k7 * t1r);
    h.im = a1.im - round_q14(k7 * t1i);
    y[4].re = h.re + t3i; y[4].im = h.im + t3r;
    y[7].re = h.re - t3i; y[7].im = h.im - t3r;

    p.re = rotate(k4, b2[0].re, k3, b2[0].im);
    p.im = rotate(k4, b2[0].im, -k3, b2[0].re);
    q.re = rotate(k2, b2[1].im, -k1, b2[1].re);
    q.im = rotate(k1, b2[1].im, k2, b2[1].re);
    t3r = round_q14(k8 * (q.re - p.re));
    t1r = p.re + q.re;
    t3i = round_q14(k8 * (p.im + q.im));
    t1i = p.im - q.im;
    y[2].re = a2.re + t1r;
    y[2].im = a2.im + t1i;
    h.re = a2.re - round_q14(k7 * t1r);
    h.im = a2.im - round_q14(k7 * t1i);
    y[5].re = h.re + t3i; y[5].im = h.im + t3r;
    y[8].re = h.re - t3i; y[8].im = h.im - t3r;

    for (int k = 0; k < 9; k++) begin
      e.re = clamp20(y[k].re);
      e.im = clamp20(y[k].im);
      e.pt = 4'(k);
      e.last = (k == 8);
      spectrum_q.push_back(e);
    end
  endtask

  task automatic absorb_point(input request_t r);
    longint sr, si, tr, ti;
    sr = r.sr; si = r.si; tr = r.tr; ti = r.ti;
    if (pt_idx == 0) begin
      twiddled_pts[0].re = sr;
      twiddled_pts[0].im = si;
    end else begin
      twiddled_pts[pt_idx].re = round_q14(sr * tr - si * ti);
      twiddled_pts[pt_idx].im = round_q14(sr * ti + si * tr);
    end
    if (pt_idx == 8) begin
      pt_idx = 0;
      predict_spectrum();
    end else begin
      pt_idx++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        absorb_point('{in_sample_re, in_sample_im, in_twiddle_re, in_twiddle_im, 1'b0});
      end
      if (start && busy) begin
        // keep presenting the same request
      end else if (hold_active && spectrum_q.size() != 0) begin
        start <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        start <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(0, 16);
        start <= 1'b0;
      end else if (pending_q.size() != 0) begin
        request_t r;
        r = pending_q.pop_front();
        if (r.hold && spectrum_q.size() != 0) begin
          hold_active <= 1'b1;
          r.hold = 1'b0;
          pending_q.push_front(r);
          start <= 1'b0;
        end else begin
          hold_active <= 1'b0;
          start <= 1'b1;
          in_sample_re <= r.sr;
          in_sample_im <= r.si;
          in_twiddle_re <= r.tr;
          in_twiddle_im <= r.ti;
        end
      end else begin
        start <= 1'b0;
        feeding_done <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (spectrum_q.size() == 0) begin
        $display("%0t: unexpected result re=%0d im=%0d point=%0d last=%0b",
                 $realtime, out_re, out_im, out_point, out_last);
        errors++;
      end else begin
        spectrum_pt_t e;
        e = spectrum_q.pop_front();
        if (out_re !== e.re || out_im !== e.im || out_point !== e.pt ||
            out_last !== e.last) begin
          $display("%0t: expected re=%0d im=%0d point=%0d last=%0b, got re=%0d im=%0d point=%0d last=%0b",
                   $realtime, e.re, e.im, e.pt, e.last,
                   out_re, out_im, out_point, out_last);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt > 2000) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic logic signed [15:0] pick_twiddle();
    case ($urandom_range(0, 9))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return -16'sd32768;
      3: return 16'sd32767;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_batch(input int kind, input bit hold_first);
    request_t r;
    for (int k = 0; k < 9; k++) begin
      case (kind)
        0: r = '{16'sh7fff, 16'sh7fff, 16'sd16384, 16'sd0, 1'b0};
        1: r = '{16'sh8000, 16'sh8000, 16'sd16384, 16'sd0, 1'b0};
        2: r = '{(k % 2) ? 16'sh8000 : 16'sh7fff, (k % 2) ? 16'sh7fff : 16'sh8000,
                 16'sh8000, 16'sh8000, 1'b0};
        3: r = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, 1'b0};
        default: r = '{pick_sample(), pick_sample(), pick_twiddle(), pick_twiddle(), 1'b0};
      endcase
      r.hold = hold_first && (k == 0);
      pending_q.push_back(r);
    end
  endtask

  initial begin
    start = 1'b0;
    in_sample_re = '0;
    in_sample_im = '0;
    in_twiddle_re = '0;
    in_twiddle_im = '0;
    rst_n = 1'b0;
    pt_idx = 0;
    errors = 0;
    idle_cnt = 0;
    stall_left = 0;
    gaps_on = 1'b1;
    feeding_done = 1'b0;
    hold_active = 1'b0;
    for (int b = 0; b < 4; b++) add_batch(b, 1'b0);
    for (int b = 0; b < 28; b++) add_batch(4, b == 10 || b == 20);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_q.size() < 50);
    gaps_on = 1'b0;
    wait (feeding_done && spectrum_q.size() == 0);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
